/* src/lcws_pkg.sv */
`timescale 1ns / 1ps

package lcws_pkg;

	localparam int DEPTH_DEF    = 24;
	localparam int RAW_BITS_DEF = 24;

	localparam int GRAMS_W    = 40;
	localparam int TIME_W     = 32;
	localparam int TARE_W     = 24;
	localparam int GAIN_W     = 32;
	localparam int LIMIT_W    = 16;
	localparam int CFG_W      = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int FRAC_SHIFT = 16;
	localparam int FLAG_W     = 3;

	localparam logic signed [TARE_W-1:0] TARE_RST  = '0;
	localparam logic signed [GAIN_W-1:0] GAIN_RST  = 32'sd16777216;
	localparam logic [LIMIT_W-1:0]       LIMIT_RST = 16'd1000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TARE  = 2'd0,
		CFG_GAIN  = 2'd1,
		CFG_CAL   = 2'd2,
		CFG_LIMIT = 2'd3
	} cfg_idx_t;

	typedef enum logic {
		OP_STORE = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DIV,
		ST_FIN
	} state_t;

	// handshake between the sequencer and the divider
	typedef struct packed {
		logic start;
	} div_req_t;

	typedef struct packed {
		logic done;
	} div_rsp_t;

endpackage

/* src/lcws_div.sv */
`timescale 1ns / 1ps

module lcws_div #(
	parameter int N_W = 45,
	parameter int D_W = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lcws_pkg::div_req_t  req,
	input  logic [N_W-1:0]      dividend,
	input  logic [D_W-1:0]      divisor,
	output lcws_pkg::div_rsp_t  rsp,
	output logic [N_W-1:0]      quotient
);
	import lcws_pkg::*;

	localparam int STEP_W = $clog2(N_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [N_W-1:0]    quo_q;
	logic [D_W-1:0]    rem_q;

	logic [D_W:0]      rem_sh;
	logic              fits;
	logic [D_W-1:0]    rem_nx;

	// restoring division, one quotient bit per cycle
	always_comb begin
		rem_sh = {rem_q, quo_q[N_W-1]};
		fits   = (rem_sh >= {1'b0, divisor});
		rem_nx = fits ? D_W'(rem_sh - {1'b0, divisor}) : rem_sh[D_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(N_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[N_W-2:0], fits};
			rem_q <= rem_nx;
		end
	end

	assign rsp.done = done_q;
	assign quotient = quo_q;

endmodule

/* src/load_cell_window_stats.sv */
`timescale 1ns / 1ps

// channel   dir   handshake                 payload
// s_*       in    s_tvalid / s_tready       s_tdata: raw_count, time_ms; s_tuser: opcode
// m_*       out   m_tvalid / m_tready       m_tdata: mean..window_span_ms; m_tuser: flags
// cfg_*     in    cfg_we                    cfg_addr, cfg_data
//
// a store writes the ring when accepted; a stale query goes straight to the finish state
// a valid query walks fill_count ring entries, one read a cycle, through a four-stage
// scaling pipeline, then a bit-serial divider gives the mean
// s_tready is high only while the sequencer idles; stores are taken while a result waits
// arst_n clears the fill count, write pointer, newest timestamp and registers to defaults

module load_cell_window_stats #(
	parameter int DEPTH    = lcws_pkg::DEPTH_DEF,
	parameter int RAW_BITS = lcws_pkg::RAW_BITS_DEF,
	localparam int CNT_W   = $clog2(DEPTH + 1),
	localparam int IN_W    = ((RAW_BITS + lcws_pkg::TIME_W + 7) / 8) * 8,
	localparam int OUT_W   = ((4 * lcws_pkg::GRAMS_W + CNT_W + lcws_pkg::TIME_W + 7) / 8) * 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [IN_W-1:0]                    s_tdata,  // raw_count, time_ms
	input  logic                               s_tuser,  // opcode
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// mean_grams, min_grams, max_grams, range_grams, held_count, window_span_ms
	output logic [OUT_W-1:0]                   m_tdata,
	output logic [lcws_pkg::FLAG_W-1:0]        m_tuser,  // stale, is_calibrated, stats_valid
	input  logic                               cfg_we,
	input  logic [lcws_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  logic [lcws_pkg::CFG_W-1:0]         cfg_data
);
	import lcws_pkg::*;

	localparam int IDX_W  = $clog2(DEPTH);
	localparam int ENT_W  = RAW_BITS + TIME_W;
	localparam int DIFF_W = ((RAW_BITS > TARE_W) ? RAW_BITS : TARE_W) + 1;
	localparam int PROD_W = DIFF_W + GAIN_W;
	localparam int SH_W   = PROD_W - FRAC_SHIFT;
	localparam int EXT_W  = (SH_W > GRAMS_W + 1) ? SH_W : GRAMS_W + 1;
	localparam int SUM_W  = GRAMS_W + $clog2(DEPTH);

	localparam logic signed [GRAMS_W-1:0] G_MAX = {1'b0, {(GRAMS_W-1){1'b1}}};
	localparam logic signed [GRAMS_W-1:0] G_MIN = {1'b1, {(GRAMS_W-1){1'b0}}};

	// configuration
	logic signed [TARE_W-1:0] tare_q;
	logic signed [GAIN_W-1:0] gain_q;
	logic                     cal_q;
	logic [LIMIT_W-1:0]       limit_q;

	// window state
	logic [IDX_W-1:0]  wr_idx_q;
	logic [CNT_W-1:0]  fill_q;
	logic [TIME_W-1:0] newest_q;

	state_t state_q, state_d;

	op_t                       in_op;
	logic signed [RAW_BITS-1:0] in_raw;
	logic [TIME_W-1:0]         in_time;
	logic [TIME_W-1:0]         age;
	logic                      stale_now;
	logic                      accept;

	logic mem_we, mem_re, out_load;
	div_req_t div_req;
	div_rsp_t div_rsp;

	logic [CNT_W-1:0] issue_q;
	logic [CNT_W-1:0] acc_cnt_q;
	logic             stale_q;

	logic [ENT_W-1:0] ring_mem [DEPTH];

	// scaling pipeline
	logic                       v_s1, v_s2, v_s3, v_s4;
	logic [ENT_W-1:0]           rd_data_s1;
	logic signed [RAW_BITS-1:0] raw_s1;
	logic signed [DIFF_W-1:0]   diff_s2;
	logic signed [PROD_W-1:0]   prod_s3;
	logic signed [GRAMS_W-1:0]  grams_s4;
	logic [TIME_W-1:0]          time_s2, time_s3, time_s4;
	logic signed [SH_W-1:0]     sh_w;
	logic signed [EXT_W-1:0]    shx_w;
	logic signed [GRAMS_W-1:0]  sat_w;

	// accumulators
	logic signed [GRAMS_W-1:0] lo_q, hi_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic [TIME_W-1:0]         tmin_q, tmax_q;
	logic [SUM_W-1:0]          sum_mag;
	logic [SUM_W-1:0]          quot;

	// output register
	logic                 m_valid_q;
	logic [GRAMS_W-1:0]   mean_q, min_q, max_q, range_q;
	logic [CNT_W-1:0]     count_q;
	logic [TIME_W-1:0]    span_q;
	logic                 stale_o_q, cal_o_q, valid_o_q;

	assign in_op     = op_t'(s_tuser);
	assign in_raw    = s_tdata[RAW_BITS-1:0];
	assign in_time   = s_tdata[RAW_BITS +: TIME_W];
	assign age       = in_time - newest_q;
	assign stale_now = (fill_q == '0) || (age > TIME_W'(limit_q));
	assign accept    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tare_q  <= TARE_RST;
			gain_q  <= GAIN_RST;
			cal_q   <= 1'b0;
			limit_q <= LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_addr))
				CFG_TARE:  tare_q  <= cfg_data[TARE_W-1:0];
				CFG_GAIN:  gain_q  <= cfg_data[GAIN_W-1:0];
				CFG_CAL:   cal_q   <= cfg_data[0];
				CFG_LIMIT: limit_q <= cfg_data[LIMIT_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_tready      = 1'b0;
		mem_we        = 1'b0;
		mem_re        = 1'b0;
		div_req.start = 1'b0;
		out_load      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (in_op == OP_STORE) begin
						mem_we = 1'b1;
					end else if (stale_now) begin
						state_d = ST_FIN;
					end else begin
						state_d = ST_WALK;
					end
				end
			end
			ST_WALK: begin
				mem_re = (issue_q != fill_q);
				if (acc_cnt_q == fill_q) begin
					div_req.start = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!m_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
		endcase
	end

	// ring write pointer, fill count and query bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q  <= '0;
			fill_q    <= '0;
			newest_q  <= '0;
			stale_q   <= 1'b0;
			issue_q   <= '0;
			acc_cnt_q <= '0;
		end else begin
			if (mem_we) begin
				wr_idx_q <= (wr_idx_q == IDX_W'(DEPTH - 1)) ? '0 : wr_idx_q + 1'b1;
				if (fill_q != CNT_W'(DEPTH)) begin
					fill_q <= fill_q + 1'b1;
				end
				newest_q <= in_time;
			end
			if (accept && in_op == OP_QUERY) begin
				stale_q   <= stale_now;
				issue_q   <= '0;
				acc_cnt_q <= '0;
			end else begin
				if (mem_re) begin
					issue_q <= issue_q + 1'b1;
				end
				if (v_s4) begin
					acc_cnt_q <= acc_cnt_q + 1'b1;
				end
			end
		end
	end

	// reads and writes never share a cycle: stores land only while idle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_mem[wr_idx_q] <= {in_time, in_raw};
		end
		if (mem_re) begin
			rd_data_s1 <= ring_mem[issue_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= mem_re;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign raw_s1 = rd_data_s1[RAW_BITS-1:0];

	// floor to q.8 by arithmetic shift, then clamp to the 40-bit range
	always_comb begin
		sh_w  = SH_W'(prod_s3 >>> FRAC_SHIFT);
		shx_w = EXT_W'(sh_w);
		if (shx_w > EXT_W'(G_MAX)) begin
			sat_w = G_MAX;
		end else if (shx_w < EXT_W'(G_MIN)) begin
			sat_w = G_MIN;
		end else begin
			sat_w = GRAMS_W'(shx_w);
		end
	end

	always_ff @(posedge clk) begin
		diff_s2  <= DIFF_W'(raw_s1) - DIFF_W'(tare_q);
		time_s2  <= rd_data_s1[RAW_BITS +: TIME_W];
		prod_s3  <= diff_s2 * gain_q;
		time_s3  <= time_s2;
		grams_s4 <= sat_w;
		time_s4  <= time_s3;
	end

	always_ff @(posedge clk) begin
		if (v_s4) begin
			if (acc_cnt_q == '0) begin
				lo_q   <= grams_s4;
				hi_q   <= grams_s4;
				sum_q  <= SUM_W'(grams_s4);
				tmin_q <= time_s4;
				tmax_q <= time_s4;
			end else begin
				if (grams_s4 < lo_q) lo_q <= grams_s4;
				if (grams_s4 > hi_q) hi_q <= grams_s4;
				sum_q <= sum_q + SUM_W'(grams_s4);
				if (time_s4 < tmin_q) tmin_q <= time_s4;
				if (time_s4 > tmax_q) tmax_q <= time_s4;
			end
		end
	end

	assign sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

	lcws_div #(
		.N_W (SUM_W),
		.D_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (sum_mag),
		.divisor  (fill_q),
		.rsp      (div_rsp),
		.quotient (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// mean truncates toward zero: divide magnitudes, restore the sign
	always_ff @(posedge clk) begin
		if (out_load) begin
			cal_o_q   <= cal_q;
			stale_o_q <= stale_q;
			valid_o_q <= !stale_q;
			if (stale_q) begin
				mean_q  <= '0;
				min_q   <= '0;
				max_q   <= '0;
				range_q <= '0;
				count_q <= '0;
				span_q  <= '0;
			end else begin
				mean_q  <= sum_q[SUM_W-1] ? GRAMS_W'(-quot) : GRAMS_W'(quot);
				min_q   <= lo_q;
				max_q   <= hi_q;
				range_q <= hi_q - lo_q;
				count_q <= fill_q;
				span_q  <= tmax_q - tmin_q;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_W'({span_q, count_q, range_q, max_q, min_q, mean_q});
	assign m_tuser  = {valid_o_q, cal_o_q, stale_o_q};

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q <= CNT_W'(DEPTH)) && (issue_q <= fill_q) && (acc_cnt_q <= issue_q))
		else $error("walk counters out of range");

	a_pipe_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 || v_s2 || v_s3 || v_s4) |-> (state_q == ST_WALK))
		else $error("scaling pipeline busy outside the walk");

	a_stale_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && stale_o_q) |-> (!valid_o_q && count_q == '0 && mean_q == '0))
		else $error("stale result carries statistics");

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && valid_o_q) |->
		($signed(min_q) <= $signed(max_q) && count_q != '0))
		else $error("minimum above maximum in a valid result");

	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !m_tready) |=> (m_valid_q && $stable(mean_q) && $stable(stale_o_q)))
		else $error("pending result changed before transfer");

endmodule
